/* sv/ring_lwe_decrypt_scale_round_unit_macros.svh */
// Assertion macros for the decryption unit's RTL, included by rlwe_core.
`ifndef RING_LWE_DECRYPT_SCALE_ROUND_UNIT_MACROS_SVH
`define RING_LWE_DECRYPT_SCALE_ROUND_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// Antecedent implies consequent in the same cycle.
`define RLWE_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("rlwe assertion failed");
// Antecedent implies consequent in the next cycle.
`define RLWE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("rlwe assertion failed");
`else
`define RLWE_ASSERT_IMPL(lbl, ante, cons)
`define RLWE_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

/* sv/rlwe_pkg.sv */
// Types and constants of the ring-LWE decryption scale-and-round unit.
`timescale 1ns / 1ps
package rlwe_pkg;

  localparam logic [1:0] OP_LOAD_KEY    = 2'd0;
  localparam logic [1:0] OP_LOAD_CIPHER = 2'd1;
  localparam logic [1:0] OP_READ        = 2'd2;

  localparam logic [1:0] MODE_DECRYPT = 2'd0;
  localparam logic [1:0] MODE_KEYMUL  = 2'd1;
  localparam logic [1:0] MODE_SCALE   = 2'd2;
  localparam logic [1:0] MODE_TEST    = 2'd3;

  localparam int unsigned PADDR_W = 6;

  localparam logic [2:0] REG_CIPHER_MOD  = 3'd0;
  localparam logic [2:0] REG_PLAIN_MOD   = 3'd1;
  localparam logic [2:0] REG_SCALE_DELTA = 3'd2;
  localparam logic [2:0] REG_HALF_DELTA  = 3'd3;
  localparam logic [2:0] REG_UPPER_THR   = 3'd4;
  localparam logic [2:0] REG_UPPER_INC   = 3'd5;
  localparam logic [2:0] REG_MODE        = 3'd6;
  localparam logic [2:0] REG_ACTIVE_CNT  = 3'd7;

  typedef struct packed {
    logic [1:0]  op;
    logic [11:0] coeff_index;
    logic [63:0] coeff_value;
    logic        last_in;
  } cmd_t;

  typedef struct packed {
    logic [11:0] out_index;
    logic [63:0] out_value;
  } rsp_t;

  typedef struct packed {
    logic [63:0] cipher_modulus;
    logic [63:0] text_modulus;
    logic [63:0] scale_delta;
    logic [62:0] half_delta;
    logic [63:0] upper_threshold;
    logic [63:0] upper_increment;
    logic [1:0]  mode;
    logic [12:0] active_count;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_KSTART,
    ST_MRD,
    ST_MUL,
    ST_RED,
    ST_DIFF,
    ST_FETCH,
    ST_LOADV,
    ST_SC1,
    ST_SC2,
    ST_DIV,
    ST_WR,
    ST_CLR
  } rlwe_state_e;

endpackage

/* sv/rlwe_mem.sv */
// Single-port-write, single-port-read synchronous memory with registered read data.
`timescale 1ns / 1ps
module rlwe_mem #(
  parameter int unsigned DEPTH = 4096,
  parameter int unsigned AW    = 12,
  parameter int unsigned W     = 64
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [W-1:0]  wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [W-1:0]  rdata_o
);

  logic [W-1:0] mem_q [DEPTH];
  logic [W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/rlwe_core.sv */
// Sequencer and datapath that compute the result polynomial into the result memory.
`timescale 1ns / 1ps
`include "ring_lwe_decrypt_scale_round_unit_macros.svh"
module rlwe_core
  import rlwe_pkg::*;
#(
  parameter int unsigned MAX_COEFFS = 4096,
  parameter int unsigned COEFF_BITS = 64,
  parameter int unsigned AW         = $clog2(MAX_COEFFS)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  cfg_t          cfg_i,
  input  logic          go_i,
  output logic          busy_o,
  output logic          c_re_o,
  output logic [AW-1:0] c_raddr_o,
  input  logic [63:0]   c_rdata_i,
  output logic          k_re_o,
  output logic [AW-1:0] k_raddr_o,
  input  logic [63:0]   k_rdata_i,
  output logic          r_we_o,
  output logic [AW-1:0] r_waddr_o,
  output logic [63:0]   r_wdata_o
);

  localparam int unsigned NW = $clog2(MAX_COEFFS + 1);
  localparam logic [63:0] CMASK = 64'((65'd1 << COEFF_BITS) - 65'd1);

  function automatic logic [63:0] smear(input logic [63:0] t);
    logic [63:0] m;
    m = t;
    m = m | (m >> 1);
    m = m | (m >> 2);
    m = m | (m >> 4);
    m = m | (m >> 8);
    m = m | (m >> 16);
    m = m | (m >> 32);
    return (t == 64'd0) ? '1 : m;
  endfunction

  rlwe_state_e state_q, state_d;

  logic [AW-1:0]  k_q, i_q;
  logic [2:0]     cnt_q;
  logic [7:0]     bc_q;
  logic           ph_q;
  logic           neg_sel_q;
  logic           quot_q;
  logic [1:0]     sh_q;
  logic [63:0]    prod_q;
  logic [191:0]   pos_q, neg_q;
  logic [63:0]    r_q, p_q, v_q, dsor_q, rem_q, dv_q;

  logic [NW-1:0]  n_c;
  logic           last_k, last_i, red_end, div_end, clr_end;
  logic [NW:0]    kd;
  logic [AW-1:0]  kaddr;
  logic [63:0]    pmask;
  logic [63:0]    pp;
  logic [1:0]     pp_sh;
  logic [191:0]   addend;
  logic           rbit;
  logic [64:0]    rsh;
  logic [63:0]    r_new;
  logic [64:0]    dsh;
  logic           dge;
  logic [64:0]    drem;
  logic [63:0]    dv_new;
  logic [64:0]    sum1;
  logic [63:0]    sc1;
  logic [63:0]    sc2;
  logic [63:0]    diff;

  // Clamp the coefficient count into 1..MAX_COEFFS.
  always_comb begin
    if (cfg_i.active_count == 13'd0) begin
      n_c = NW'(1);
    end else if (32'(cfg_i.active_count) > 32'(MAX_COEFFS)) begin
      n_c = NW'(MAX_COEFFS);
    end else begin
      n_c = NW'(cfg_i.active_count);
    end
  end

  assign last_k  = (NW'(k_q) == n_c - NW'(1));
  assign last_i  = (NW'(i_q) == n_c - NW'(1));
  assign red_end = (bc_q == 8'd191);
  assign div_end = (bc_q == 8'd63);
  assign clr_end = (k_q == AW'(MAX_COEFFS - 1));
  assign pmask   = smear(cfg_i.text_modulus);

  // Negacyclic key index: k-i, wrapped by n when i exceeds k.
  always_comb begin
    kd = (NW + 1)'(k_q) - (NW + 1)'(i_q);
    if (i_q > k_q) begin
      kd = kd + (NW + 1)'(n_c);
    end
    kaddr = AW'(kd);
  end

  // One 32x32 partial product per cycle.
  always_comb begin
    case (cnt_q)
      3'd0: begin
        pp = 64'(c_rdata_i[31:0] * k_rdata_i[31:0]);
        pp_sh = 2'd0;
      end
      3'd1: begin
        pp = 64'(c_rdata_i[31:0] * k_rdata_i[63:32]);
        pp_sh = 2'd1;
      end
      3'd2: begin
        pp = 64'(c_rdata_i[63:32] * k_rdata_i[31:0]);
        pp_sh = 2'd1;
      end
      default: begin
        pp = 64'(c_rdata_i[63:32] * k_rdata_i[63:32]);
        pp_sh = 2'd2;
      end
    endcase
  end

  always_comb begin
    case (sh_q)
      2'd0:    addend = {128'd0, prod_q};
      2'd1:    addend = {96'd0, prod_q, 32'd0};
      default: addend = {64'd0, prod_q, 64'd0};
    endcase
  end

  // Bit-serial reduction step of the 192-bit accumulator modulo q.
  always_comb begin
    rbit  = ph_q ? neg_q[191] : pos_q[191];
    rsh   = {r_q, rbit};
    r_new = (rsh[64] || (rsh[63:0] >= cfg_i.cipher_modulus)) ?
            (rsh[63:0] - cfg_i.cipher_modulus) : rsh[63:0];
  end

  // Restoring division step; the quotient shifts into dv_q.
  always_comb begin
    dsh    = {rem_q, dv_q[63]};
    dge    = (dsh >= {1'b0, dsor_q});
    drem   = dge ? (dsh - {1'b0, dsor_q}) : dsh;
    dv_new = {dv_q[62:0], dge};
  end

  always_comb begin
    sum1 = {1'b0, v_q} + {2'b0, cfg_i.half_delta};
    if ((cfg_i.cipher_modulus != 64'd0) &&
        (sum1[64] || (sum1[63:0] >= cfg_i.cipher_modulus))) begin
      sc1 = sum1[63:0] - cfg_i.cipher_modulus;
    end else begin
      sc1 = sum1[63:0];
    end
    sc2 = (v_q >= cfg_i.upper_threshold) ? (v_q - cfg_i.upper_increment) : v_q;
    diff = p_q - r_q;
    if (p_q < r_q) begin
      diff = diff + cfg_i.cipher_modulus;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (go_i) state_d = ST_KSTART;
      ST_KSTART: begin
        state_d = (cfg_i.mode == MODE_SCALE || cfg_i.mode == MODE_TEST) ? ST_FETCH : ST_MRD;
      end
      ST_MRD:    state_d = ST_MUL;
      ST_MUL: begin
        if (cnt_q == 3'd4) begin
          state_d = last_i ? ST_RED : ST_MRD;
        end
      end
      ST_RED:    if (red_end && ph_q) state_d = ST_DIFF;
      ST_DIFF:   state_d = (cfg_i.mode == MODE_DECRYPT) ? ST_SC1 : ST_WR;
      ST_FETCH:  state_d = ST_LOADV;
      ST_LOADV: begin
        if (cfg_i.mode == MODE_SCALE) begin
          state_d = ST_SC1;
        end else begin
          state_d = (cfg_i.text_modulus != 64'd0) ? ST_DIV : ST_WR;
        end
      end
      ST_SC1:    state_d = ST_SC2;
      ST_SC2:    state_d = (cfg_i.scale_delta == 64'd0) ? ST_WR : ST_DIV;
      ST_DIV:    if (div_end) state_d = ST_WR;
      ST_WR: begin
        if (!last_k) begin
          state_d = ST_KSTART;
        end else begin
          state_d = (n_c == NW'(MAX_COEFFS)) ? ST_IDLE : ST_CLR;
        end
      end
      ST_CLR:    if (clr_end) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // Memory port controls.
  always_comb begin
    c_re_o    = 1'b0;
    c_raddr_o = k_q;
    k_re_o    = 1'b0;
    k_raddr_o = kaddr;
    r_we_o    = 1'b0;
    r_waddr_o = k_q;
    r_wdata_o = v_q & CMASK;
    unique case (state_q)
      ST_MRD: begin
        c_re_o    = 1'b1;
        c_raddr_o = i_q;
        k_re_o    = 1'b1;
      end
      ST_FETCH: c_re_o = 1'b1;
      ST_WR:    r_we_o = 1'b1;
      ST_CLR: begin
        r_we_o    = 1'b1;
        r_wdata_o = '0;
      end
      default: ;
    endcase
  end

  assign busy_o = (state_q != ST_IDLE);

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      k_q     <= '0;
      i_q     <= '0;
      cnt_q   <= '0;
      bc_q    <= '0;
      ph_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      case (state_q)
        ST_IDLE:   k_q <= '0;
        ST_KSTART: i_q <= '0;
        ST_MRD:    cnt_q <= '0;
        ST_MUL: begin
          cnt_q <= cnt_q + 3'd1;
          if (cnt_q == 3'd4) begin
            i_q  <= i_q + AW'(1);
            bc_q <= '0;
            ph_q <= 1'b0;
          end
        end
        ST_RED: begin
          bc_q <= red_end ? 8'd0 : (bc_q + 8'd1);
          if (red_end) begin
            ph_q <= 1'b1;
          end
        end
        ST_LOADV, ST_SC2: bc_q <= '0;
        ST_DIV:    bc_q <= bc_q + 8'd1;
        ST_WR:     k_q <= last_k ? AW'(n_c) : (k_q + AW'(1));
        ST_CLR:    k_q <= k_q + AW'(1);
        default: ;
      endcase
    end
  end

  // Datapath.
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_KSTART: begin
        pos_q <= '0;
        neg_q <= '0;
        r_q   <= '0;
      end
      ST_MRD: neg_sel_q <= (i_q > k_q);
      ST_MUL: begin
        if (cnt_q != 3'd4) begin
          prod_q <= pp;
          sh_q   <= pp_sh;
        end
        if (cnt_q != 3'd0) begin
          if (neg_sel_q) begin
            neg_q <= neg_q + addend;
          end else begin
            pos_q <= pos_q + addend;
          end
        end
      end
      ST_RED: begin
        if (ph_q) begin
          neg_q <= {neg_q[190:0], 1'b0};
          r_q   <= r_new;
        end else begin
          pos_q <= {pos_q[190:0], 1'b0};
          if (red_end) begin
            p_q <= r_new;
            r_q <= '0;
          end else begin
            r_q <= r_new;
          end
        end
      end
      ST_DIFF: v_q <= diff;
      ST_LOADV: begin
        v_q    <= c_rdata_i;
        dv_q   <= c_rdata_i;
        dsor_q <= cfg_i.text_modulus;
        rem_q  <= '0;
        quot_q <= 1'b0;
      end
      ST_SC1: v_q <= sc1;
      ST_SC2: begin
        v_q    <= pmask;
        dv_q   <= sc2;
        dsor_q <= cfg_i.scale_delta;
        rem_q  <= '0;
        quot_q <= 1'b1;
      end
      ST_DIV: begin
        dv_q  <= dv_new;
        rem_q <= drem[63:0];
        if (div_end) begin
          v_q <= quot_q ? (dv_new & pmask) : drem[63:0];
        end
      end
      default: ;
    endcase
  end

  `RLWE_ASSERT_IMPL(a_go_when_idle, go_i, state_q == ST_IDLE)
  `RLWE_ASSERT_IMPL(a_key_addr_in_range, state_q == ST_MRD, (NW + 1)'(kaddr) < (NW + 1)'(n_c))
  `RLWE_ASSERT_NEXT(a_div_rem_below, state_q == ST_DIV, rem_q < dsor_q)
  `RLWE_ASSERT_NEXT(a_clear_writes_zero, state_q == ST_CLR && !clr_end, r_we_o && r_wdata_o == 64'd0)

endmodule

/* sv/ring_lwe_decrypt_scale_round_unit.sv */
// Top level of the ring-LWE decryption scale-and-round unit.
`timescale 1ns / 1ps
// This unit holds a secret-key polynomial, a ciphertext polynomial and a result
// polynomial in three on-chip memories of MAX_COEFFS words each. Commands enter
// through start and busy: a command is taken at a clock edge where start is high
// and busy is low. Key and ciphertext loads and result reads may be issued back
// to back. A read returns its item on result_o in the cycle after it is taken,
// marked by out_valid_o for exactly one cycle; the receiver cannot stall, so it
// must take every item on the cycle it appears. A ciphertext load with last_in
// set starts the computation, and busy stays high until the whole result
// polynomial is written. The computation is sequenced around the memories: in
// decrypt and key-multiply modes, for each result coefficient the unit walks all
// N ciphertext and key coefficients, one memory read pair followed by four 32x32
// partial products into one of two 192-bit accumulators. The accumulators are
// then reduced modulo q bit-serially, and in full decrypt mode the rounding
// steps SC1 and SC2 are followed by a restoring division by scale_delta when it
// is nonzero. Scale-only and test modes skip the multiply. After the last
// coefficient, entries from N up to MAX_COEFFS are cleared at one per cycle. The
// memories are not initialized: every key and ciphertext entry below N must be
// loaded before a computation, and results are valid only after one.
// Configuration goes through the APB-style port and must only be written
// while the unit is idle.
module ring_lwe_decrypt_scale_round_unit
  import rlwe_pkg::*;
#(
  parameter int unsigned MAX_COEFFS = 4096,
  parameter int unsigned COEFF_BITS = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  cmd_t               cmd_i,
  output logic               out_valid_o,
  output rsp_t               result_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [63:0]        pwdata,
  output logic [63:0]        prdata,
  output logic               pready
);

  localparam int unsigned AW = $clog2(MAX_COEFFS);
  localparam logic [63:0] CMASK = 64'((65'd1 << COEFF_BITS) - 65'd1);

  cfg_t cfg_q;

  logic          accept;
  logic          idx_ok;
  logic [AW-1:0] idx_addr;
  logic [63:0]   load_val;
  logic          cfg_we;
  logic [2:0]    reg_idx;

  logic          core_busy;
  logic          go;
  logic          c_re, k_re, r_we;
  logic [AW-1:0] c_raddr, k_raddr, r_waddr;
  logic [63:0]   c_rdata, k_rdata, r_wdata, r_rdata;

  logic          rd_v_q;
  logic          rd_ok_q;
  logic [11:0]   rd_idx_q;

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite && pready;
  assign reg_idx = paddr[PADDR_W-1:3];

  // Configuration registers; each write keeps only the register's width.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.cipher_modulus  <= 64'd2;
      cfg_q.text_modulus    <= 64'd2;
      cfg_q.scale_delta     <= 64'd1;
      cfg_q.half_delta      <= 63'd0;
      cfg_q.upper_threshold <= 64'd1;
      cfg_q.upper_increment <= 64'd0;
      cfg_q.mode            <= MODE_DECRYPT;
      cfg_q.active_count    <= 13'd4096;
    end else if (cfg_we) begin
      unique case (reg_idx)
        REG_CIPHER_MOD:  cfg_q.cipher_modulus  <= pwdata;
        REG_PLAIN_MOD:   cfg_q.text_modulus    <= pwdata;
        REG_SCALE_DELTA: cfg_q.scale_delta     <= pwdata;
        REG_HALF_DELTA:  cfg_q.half_delta      <= pwdata[62:0];
        REG_UPPER_THR:   cfg_q.upper_threshold <= pwdata;
        REG_UPPER_INC:   cfg_q.upper_increment <= pwdata;
        REG_MODE:        cfg_q.mode            <= pwdata[1:0];
        REG_ACTIVE_CNT:  cfg_q.active_count    <= pwdata[12:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_CIPHER_MOD:  prdata = cfg_q.cipher_modulus;
      REG_PLAIN_MOD:   prdata = cfg_q.text_modulus;
      REG_SCALE_DELTA: prdata = cfg_q.scale_delta;
      REG_HALF_DELTA:  prdata = {1'b0, cfg_q.half_delta};
      REG_UPPER_THR:   prdata = cfg_q.upper_threshold;
      REG_UPPER_INC:   prdata = cfg_q.upper_increment;
      REG_MODE:        prdata = {62'd0, cfg_q.mode};
      REG_ACTIVE_CNT:  prdata = {51'd0, cfg_q.active_count};
      default:         prdata = '0;
    endcase
  end

  // Command decode. Indices past the memory are dropped on loads and read as zero.
  assign busy     = core_busy;
  assign accept   = start && !busy;
  assign idx_ok   = ({20'd0, cmd_i.coeff_index} < 32'(MAX_COEFFS));
  assign idx_addr = AW'(cmd_i.coeff_index);
  assign load_val = cmd_i.coeff_value & CMASK;
  assign go       = accept && (cmd_i.op == OP_LOAD_CIPHER) && cmd_i.last_in;

  rlwe_mem #(.DEPTH(MAX_COEFFS), .AW(AW), .W(64)) u_key_mem (
    .clk_i   (clk_i),
    .we_i    (accept && (cmd_i.op == OP_LOAD_KEY) && idx_ok),
    .waddr_i (idx_addr),
    .wdata_i (load_val),
    .re_i    (k_re),
    .raddr_i (k_raddr),
    .rdata_o (k_rdata)
  );

  rlwe_mem #(.DEPTH(MAX_COEFFS), .AW(AW), .W(64)) u_cipher_mem (
    .clk_i   (clk_i),
    .we_i    (accept && (cmd_i.op == OP_LOAD_CIPHER) && idx_ok),
    .waddr_i (idx_addr),
    .wdata_i (load_val),
    .re_i    (c_re),
    .raddr_i (c_raddr),
    .rdata_o (c_rdata)
  );

  rlwe_mem #(.DEPTH(MAX_COEFFS), .AW(AW), .W(64)) u_result_mem (
    .clk_i   (clk_i),
    .we_i    (r_we),
    .waddr_i (r_waddr),
    .wdata_i (r_wdata),
    .re_i    (accept && (cmd_i.op == OP_READ)),
    .raddr_i (idx_addr),
    .rdata_o (r_rdata)
  );

  rlwe_core #(.MAX_COEFFS(MAX_COEFFS), .COEFF_BITS(COEFF_BITS), .AW(AW)) u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .go_i      (go),
    .busy_o    (core_busy),
    .c_re_o    (c_re),
    .c_raddr_o (c_raddr),
    .c_rdata_i (c_rdata),
    .k_re_o    (k_re),
    .k_raddr_o (k_raddr),
    .k_rdata_i (k_rdata),
    .r_we_o    (r_we),
    .r_waddr_o (r_waddr),
    .r_wdata_o (r_wdata)
  );

  // A read item leaves in the cycle after it is taken, straight from
  // the memory's read register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_v_q <= 1'b0;
    end else begin
      rd_v_q <= accept && (cmd_i.op == OP_READ);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && (cmd_i.op == OP_READ)) begin
      rd_idx_q <= cmd_i.coeff_index;
      rd_ok_q  <= idx_ok;
    end
  end

  assign out_valid_o         = rd_v_q;
  assign result_o.out_index  = rd_idx_q;
  assign result_o.out_value  = rd_ok_q ? r_rdata : 64'd0;

endmodule
